@@ rtl/mrs_pkg.sv @@
package mrs_pkg;

	// Matrix shape
	localparam int NUM_ROWS = 5;
	localparam int NUM_COLS = 5;

	// Field widths of the transaction ports
	localparam int WORD_W = 32;
	localparam int IDX_W  = 3;

	// Internal index widths follow the matrix shape
	localparam int RIDX_W = $clog2(NUM_ROWS);
	localparam int CIDX_W = $clog2(NUM_COLS);

	// One odd-even transposition pass per element of the longer line
	localparam int SORT_PASSES = (NUM_ROWS > NUM_COLS) ? NUM_ROWS : NUM_COLS;
	localparam int PASS_W      = $clog2(SORT_PASSES);

	typedef logic signed [WORD_W-1:0] word_t;

	typedef enum logic [2:0] {
		FN_WRITE     = 3'd0,
		FN_READ      = 3'd1,
		FN_ROT_RIGHT = 3'd2,
		FN_ROT_LEFT  = 3'd3,
		FN_ROT_UP    = 3'd4,
		FN_ROT_DOWN  = 3'd5,
		FN_SORT_COLS = 3'd6,
		FN_SORT_ROWS = 3'd7
	} func_t;

	// What one cell loads in the next cycle
	typedef enum logic [3:0] {
		CO_HOLD,
		CO_LOAD,
		CO_FROM_W,
		CO_FROM_E,
		CO_FROM_N,
		CO_FROM_S,
		CO_MIN_E,
		CO_MAX_W,
		CO_MIN_S,
		CO_MAX_N
	} cell_op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SORT,
		ST_RESULT
	} state_t;

	// Control handed from the sequencer to the cell array
	typedef struct packed {
		logic              apply;
		func_t             func;
		logic              phase;
		logic              ok;
		logic [RIDX_W-1:0] row;
		logic [CIDX_W-1:0] col;
	} ctl_t;

endpackage

@@ rtl/mrs_cell.sv @@
module mrs_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  mrs_pkg::cell_op_t op,
	input  mrs_pkg::word_t    wdata,
	input  mrs_pkg::word_t    val_w,
	input  mrs_pkg::word_t    val_e,
	input  mrs_pkg::word_t    val_n,
	input  mrs_pkg::word_t    val_s,
	output mrs_pkg::word_t    val
);

	mrs_pkg::word_t val_q;
	mrs_pkg::word_t val_d;

	// Pick the next element: load, shift in from a neighbour, or compare-exchange
	always_comb begin
		case (op)
			mrs_pkg::CO_HOLD:   val_d = val_q;
			mrs_pkg::CO_LOAD:   val_d = wdata;
			mrs_pkg::CO_FROM_W: val_d = val_w;
			mrs_pkg::CO_FROM_E: val_d = val_e;
			mrs_pkg::CO_FROM_N: val_d = val_n;
			mrs_pkg::CO_FROM_S: val_d = val_s;
			mrs_pkg::CO_MIN_E:  val_d = (val_e < val_q) ? val_e : val_q;
			mrs_pkg::CO_MAX_W:  val_d = (val_w > val_q) ? val_w : val_q;
			mrs_pkg::CO_MIN_S:  val_d = (val_s < val_q) ? val_s : val_q;
			mrs_pkg::CO_MAX_N:  val_d = (val_n > val_q) ? val_n : val_q;
			default:            val_d = val_q;
		endcase
	end

	// Hold the element; the store clears at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
		end else begin
			val_q <= val_d;
		end
	end

	assign val = val_q;

endmodule

@@ rtl/mrs_ctrl.sv @@
module mrs_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  logic [mrs_pkg::IDX_W-1:0]    func,
	input  logic [mrs_pkg::IDX_W-1:0]    row_index,
	input  logic [mrs_pkg::IDX_W-1:0]    col_index,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	input  mrs_pkg::word_t               rd_data,
	output mrs_pkg::word_t               read_value,
	output mrs_pkg::ctl_t                ctl
);

	mrs_pkg::state_t                state_q, state_d;
	mrs_pkg::func_t                 func_q;
	logic [mrs_pkg::RIDX_W-1:0]     row_q;
	logic [mrs_pkg::CIDX_W-1:0]     col_q;
	logic                           ok_q;
	logic [mrs_pkg::PASS_W-1:0]     pass_q;
	logic                           rsp_valid_q;
	mrs_pkg::word_t                 read_value_q;

	mrs_pkg::func_t                 in_func;
	logic                           in_ok;
	logic                           accept;
	logic                           in_sort;
	logic                           last_pass;
	logic                           rsp_load;

	assign in_func   = mrs_pkg::func_t'(func);
	assign in_ok     = (32'(row_index) < 32'(mrs_pkg::NUM_ROWS))
	                && (32'(col_index) < 32'(mrs_pkg::NUM_COLS));
	assign accept    = req_valid && (state_q == mrs_pkg::ST_IDLE);
	assign in_sort   = (in_func == mrs_pkg::FN_SORT_COLS) || (in_func == mrs_pkg::FN_SORT_ROWS);
	assign last_pass = (pass_q == mrs_pkg::PASS_W'(mrs_pkg::SORT_PASSES - 1));
	assign rsp_load  = (state_q == mrs_pkg::ST_RESULT) && (!rsp_valid_q || !rsp_stall);

	// Next state and cell array control
	always_comb begin
		state_d   = state_q;
		req_stall = (state_q != mrs_pkg::ST_IDLE);
		ctl.apply = 1'b0;
		ctl.func  = func_q;
		ctl.phase = pass_q[0];
		ctl.ok    = ok_q;
		ctl.row   = row_q;
		ctl.col   = col_q;
		case (state_q)
			mrs_pkg::ST_IDLE: begin
				ctl.func  = in_func;
				ctl.ok    = in_ok;
				ctl.row   = mrs_pkg::RIDX_W'(row_index);
				ctl.col   = mrs_pkg::CIDX_W'(col_index);
				ctl.apply = accept && !in_sort;
				if (accept) begin
					state_d = in_sort ? mrs_pkg::ST_SORT : mrs_pkg::ST_RESULT;
				end
			end
			mrs_pkg::ST_SORT: begin
				ctl.apply = 1'b1;
				if (last_pass) begin
					state_d = mrs_pkg::ST_RESULT;
				end
			end
			mrs_pkg::ST_RESULT: begin
				if (rsp_load) begin
					state_d = mrs_pkg::ST_IDLE;
				end
			end
			default: state_d = mrs_pkg::ST_IDLE;
		endcase
	end

	// Advance the sequencer and capture the transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mrs_pkg::ST_IDLE;
			pass_q  <= '0;
			func_q  <= mrs_pkg::FN_READ;
			row_q   <= '0;
			col_q   <= '0;
			ok_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				func_q <= in_func;
				row_q  <= mrs_pkg::RIDX_W'(row_index);
				col_q  <= mrs_pkg::CIDX_W'(col_index);
				ok_q   <= in_ok;
				pass_q <= '0;
			end else if (state_q == mrs_pkg::ST_SORT) begin
				pass_q <= pass_q + 1'b1;
			end
		end
	end

	// Output register: load the addressed element (zero when out of range), drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp_load) begin
			read_value_q <= ok_q ? rd_data : '0;
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign read_value = read_value_q;

endmodule

@@ rtl/matrix_rotate_sort_engine.sv @@
// Write and rotations update the cell array at acceptance; the two sorts instead run
// the odd-even transposition passes through the cell array in the sort state. Every
// function then loads the addressed element into the output register in the result
// state. A new transaction is accepted only after the previous result is loaded, so a
// waiting result that is still stalled blocks the next acceptance.
// Reset clears every matrix element to zero and empties the output register.
module matrix_rotate_sort_engine (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	output logic                         req_stall,
	input  logic [2:0]                   func,
	input  logic [2:0]                   row_index,
	input  logic [2:0]                   col_index,
	input  logic signed [31:0]           write_value,
	output logic                         rsp_valid,
	input  logic                         rsp_stall,
	output logic signed [31:0]           read_value
);

	mrs_pkg::ctl_t  ctl;
	mrs_pkg::word_t rd_data;
	mrs_pkg::word_t mat [mrs_pkg::NUM_ROWS][mrs_pkg::NUM_COLS];

	mrs_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.func       (func),
		.row_index  (row_index),
		.col_index  (col_index),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rd_data    (rd_data),
		.read_value (read_value),
		.ctl        (ctl)
	);

	// Read the addressed element; out-of-range addresses are masked by the sequencer
	assign rd_data = mat[ctl.row][ctl.col];

	// Array of cells, wrapped at the edges for the rotations
	for (genvar r = 0; r < mrs_pkg::NUM_ROWS; r++) begin : g_row
		for (genvar c = 0; c < mrs_pkg::NUM_COLS; c++) begin : g_col
			localparam int RN = (r + mrs_pkg::NUM_ROWS - 1) % mrs_pkg::NUM_ROWS;
			localparam int RS = (r + 1) % mrs_pkg::NUM_ROWS;
			localparam int CW = (c + mrs_pkg::NUM_COLS - 1) % mrs_pkg::NUM_COLS;
			localparam int CE = (c + 1) % mrs_pkg::NUM_COLS;
			localparam logic R_ODD = 1'(r % 2);
			localparam logic C_ODD = 1'(c % 2);
			localparam logic HAS_S = (r + 1 < mrs_pkg::NUM_ROWS);
			localparam logic HAS_N = (r > 0);
			localparam logic HAS_E = (c + 1 < mrs_pkg::NUM_COLS);
			localparam logic HAS_W = (c > 0);

			mrs_pkg::cell_op_t op;

			// Decode the cell's move; sort pairs alternate with the pass parity
			always_comb begin
				op = mrs_pkg::CO_HOLD;
				if (ctl.apply) begin
					case (ctl.func)
						mrs_pkg::FN_WRITE: begin
							if (ctl.ok && (ctl.row == mrs_pkg::RIDX_W'(r))
							    && (ctl.col == mrs_pkg::CIDX_W'(c))) begin
								op = mrs_pkg::CO_LOAD;
							end
						end
						mrs_pkg::FN_ROT_RIGHT: op = mrs_pkg::CO_FROM_W;
						mrs_pkg::FN_ROT_LEFT:  op = mrs_pkg::CO_FROM_E;
						mrs_pkg::FN_ROT_UP:    op = mrs_pkg::CO_FROM_S;
						mrs_pkg::FN_ROT_DOWN:  op = mrs_pkg::CO_FROM_N;
						mrs_pkg::FN_SORT_COLS: begin
							if (R_ODD == ctl.phase) begin
								if (HAS_S) op = mrs_pkg::CO_MIN_S;
							end else if (HAS_N) begin
								op = mrs_pkg::CO_MAX_N;
							end
						end
						mrs_pkg::FN_SORT_ROWS: begin
							if (C_ODD == ctl.phase) begin
								if (HAS_E) op = mrs_pkg::CO_MIN_E;
							end else if (HAS_W) begin
								op = mrs_pkg::CO_MAX_W;
							end
						end
						default: op = mrs_pkg::CO_HOLD;
					endcase
				end
			end

			mrs_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.op     (op),
				.wdata  (write_value),
				.val_w  (mat[r][CW]),
				.val_e  (mat[r][CE]),
				.val_n  (mat[RN][c]),
				.val_s  (mat[RS][c]),
				.val    (mat[r][c])
			);
		end
	end

endmodule
